// ----- design/bpc_pkg.sv -----
// Shared types, constants and reset values for the beacon period classifier.
`default_nettype none

package bpc_pkg;

   localparam int EDGE_W      = 32;
   localparam int PERIOD_W    = 16;
   localparam int CODE_W      = 3;
   localparam int TOL_W       = 8;
   localparam int COUNT_W     = 3;
   localparam int NOMINAL_W   = 12;
   localparam int BEACON_COUNT = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam int US_PER_MS = 1000;
   localparam int US_W      = 10;

   localparam int RING_DEPTH_DEFAULT   = 4;
   localparam int TICKS_PER_MS_DEFAULT = 40000;

   // reciprocal multiply: bits of the reciprocal consumed per clock
   localparam int RECIP_CHUNK_W = 16;

   typedef logic [CODE_W-1:0] code_type;
   localparam code_type CODE_INVALID = 3'd5;

   typedef logic [BEACON_COUNT-1:0][NOMINAL_W-1:0] nominal_array_type;

   localparam nominal_array_type NOMINAL_RESET = {12'd455, 12'd513, 12'd588, 12'd690, 12'd800};
   localparam logic [TOL_W-1:0]   TOL_RESET    = 8'd10;
   localparam logic [COUNT_W-1:0] SAMPLE_RESET = 3'd4;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_TOLERANCE    = 3'd0;
   localparam csr_index_type REG_SAMPLE_COUNT = 3'd1;
   localparam csr_index_type REG_NOMINAL_0    = 3'd2;
   localparam csr_index_type REG_NOMINAL_4    = 3'd6;

   typedef struct packed {
      logic capture;
      logic load;
      logic div_step;
      logic ring_write;
      logic sweep_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic sweep_last;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- design/bpc_classifier.sv -----
// Window classifier: maps one period to a beacon index or the invalid code.
`default_nettype none

module bpc_classifier (
   input  logic [bpc_pkg::PERIOD_W-1:0]  period,
   input  logic [bpc_pkg::TOL_W-1:0]     tolerance,
   input  bpc_pkg::nominal_array_type    nominal,
   output bpc_pkg::code_type             code
);
   import bpc_pkg::*;

   localparam int SW = PERIOD_W + 1;

   always_comb begin
      logic [SW-1:0] p_ext;
      logic [SW-1:0] tol_ext;
      logic [SW-1:0] p_plus_tol;
      logic          outer_ok;
      logic          found;
      p_ext      = {1'b0, period};
      tol_ext    = SW'(tolerance);
      p_plus_tol = p_ext + tol_ext;
      // p > c - tol is taken as p + tol > c, so no bound goes negative
      outer_ok   = (p_ext < (SW'(nominal[0]) + tol_ext)) &&
                   (p_plus_tol > SW'(nominal[BEACON_COUNT-1]));
      found      = 1'b0;
      code       = CODE_INVALID;
      for (int k = 0; k < BEACON_COUNT; k++) begin
         if (!found && (p_plus_tol > SW'(nominal[k])) &&
             (p_ext < (SW'(nominal[k]) + tol_ext))) begin
            code  = code_type'(k);
            found = 1'b1;
         end
      end
      if (!outer_ok) begin
         code = CODE_INVALID;
      end
   end

endmodule

`default_nettype wire

// ----- design/bpc_datapath.sv -----
// Datapath: config registers, period scaling, period ring and agreement sweep.
`default_nettype none

module bpc_datapath #(
   parameter int RING_DEPTH   = bpc_pkg::RING_DEPTH_DEFAULT,
   parameter int TICKS_PER_MS = bpc_pkg::TICKS_PER_MS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bpc_pkg::ctrl_cmd_type           cmd,
   output bpc_pkg::ctrl_status_type        status,
   input  logic [bpc_pkg::EDGE_W-1:0]      edge_time,
   input  logic                            csr_we,
   input  bpc_pkg::csr_index_type          csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [bpc_pkg::PERIOD_W-1:0]    period_us,
   output bpc_pkg::code_type               latest_code,
   output bpc_pkg::code_type               agreed_code
);
   import bpc_pkg::*;

   localparam int PW     = EDGE_W + US_W;
   localparam int LW     = $clog2(TICKS_PER_MS);
   localparam int XW     = LW + PERIOD_W;
   localparam int RSHIFT = XW + LW;
   localparam int MCH    = (XW + 2 + RECIP_CHUNK_W - 1) / RECIP_CHUNK_W;
   localparam int MRW    = MCH * RECIP_CHUNK_W;
   localparam int AW     = XW + MRW;
   localparam int PPW    = XW + RECIP_CHUNK_W;
   localparam int IW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW     = $clog2(RING_DEPTH + 1);
   localparam int STEP_W = (MCH > 1) ? $clog2(MCH) : 1;

   localparam logic [PW-1:0]       SAT_LIMIT  = PW'(TICKS_PER_MS) << PERIOD_W;
   // ceil(2^RSHIFT / TICKS_PER_MS) gives the exact floor quotient for any x below 2^XW
   localparam logic [MRW-1:0]      RECIP      =
      MRW'(((64'd1 << RSHIFT) + 64'(TICKS_PER_MS) - 64'd1) / 64'(TICKS_PER_MS));
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

   // configuration
   logic [TOL_W-1:0]   tol_ff;
   logic [COUNT_W-1:0] sample_ff;
   nominal_array_type  nominal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= TOL_RESET;
         sample_ff  <= SAMPLE_RESET;
         nominal_ff <= NOMINAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_TOLERANCE:    tol_ff    <= csr_wdata[TOL_W-1:0];
            REG_SAMPLE_COUNT: sample_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
               if (csr_index inside {[REG_NOMINAL_0:REG_NOMINAL_4]}) begin
                  nominal_ff[csr_index - REG_NOMINAL_0] <= csr_wdata[NOMINAL_W-1:0];
               end
            end
         endcase
      end
   end

   // edge difference and scaling to microseconds
   logic [EDGE_W-1:0]   prev_edge_ff;
   logic [EDGE_W-1:0]   diff;
   logic [PW-1:0]       product_ff;
   logic                sat_ff;
   logic [XW-1:0]       x_ff;
   logic [MRW-1:0]      recip_ff;
   logic [AW-1:0]       acc_ff;
   logic [AW-1:0]       acc_in;
   logic [PPW-1:0]      partial;
   logic [STEP_W-1:0]   step_ff;
   logic [PERIOD_W-1:0] period_now;

   assign diff = edge_time - prev_edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_edge_ff <= '0;
      end else if (cmd.capture) begin
         prev_edge_ff <= edge_time;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         product_ff <= PW'(diff) * PW'(US_PER_MS);
      end
   end

   // one reciprocal chunk per clock, most significant first (Horner accumulation)
   assign partial = PPW'(x_ff) * PPW'(recip_ff[MRW-1 -: RECIP_CHUNK_W]);
   assign acc_in  = (acc_ff << RECIP_CHUNK_W) + AW'(partial);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         // unsaturated products always fit in XW bits
         sat_ff   <= (product_ff >= SAT_LIMIT);
         x_ff     <= product_ff[XW-1:0];
         recip_ff <= RECIP;
         acc_ff   <= '0;
      end else if (cmd.div_step) begin
         recip_ff <= recip_ff << RECIP_CHUNK_W;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign period_now = sat_ff ? PERIOD_MAX : acc_ff[RSHIFT +: PERIOD_W];

   // period ring
   logic [PERIOD_W-1:0] ring_ff [RING_DEPTH];
   logic [IW-1:0]       wr_ff;
   logic [IW-1:0]       wr_eff;
   logic [IW-1:0]       wr_in;
   logic [CW-1:0]       count_eff;

   always_comb begin
      if (sample_ff == '0) begin
         count_eff = CW'(1);
      end else if (int'(sample_ff) > RING_DEPTH) begin
         count_eff = CW'(RING_DEPTH);
      end else begin
         count_eff = CW'(sample_ff);
      end
   end

   // a shrunken count sends the write back to slot zero
   assign wr_eff = (CW'(wr_ff) >= count_eff) ? '0 : wr_ff;
   assign wr_in  = ((CW'(wr_eff) + CW'(1)) >= count_eff) ? '0 : wr_eff + IW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= '{default: '0};
         wr_ff   <= '0;
      end else if (cmd.ring_write) begin
         ring_ff[wr_eff] <= period_now;
         wr_ff           <= wr_in;
      end
   end

   // shared classifier: new period on the ring write, then one slot per sweep step
   logic [IW-1:0]       sweep_idx_ff;
   logic [PERIOD_W-1:0] cls_period;
   code_type            cls_code;
   code_type            latest_ff;
   code_type            first_ff;
   code_type            agreed_ff;

   assign cls_period = cmd.ring_write ? period_now : ring_ff[sweep_idx_ff];

   bpc_classifier u_classifier (
      .period    (cls_period),
      .tolerance (tol_ff),
      .nominal   (nominal_ff),
      .code      (cls_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_idx_ff <= '0;
      end else if (cmd.ring_write) begin
         sweep_idx_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_idx_ff <= sweep_idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_write) begin
         latest_ff <= cls_code;
      end
      if (cmd.sweep_step) begin
         if (sweep_idx_ff == '0) begin
            first_ff  <= cls_code;
            agreed_ff <= cls_code;
         end else if (cls_code != first_ff) begin
            agreed_ff <= CODE_INVALID;
         end
      end
   end

   assign status.div_last   = (step_ff == STEP_W'(MCH - 1));
   assign status.sweep_last = ((CW'(sweep_idx_ff) + CW'(1)) == count_eff);

   // result register
   logic [PERIOD_W-1:0] rsp_period_ff;
   code_type            rsp_latest_ff;
   code_type            rsp_agreed_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_period_ff <= period_now;
         rsp_latest_ff <= latest_ff;
         rsp_agreed_ff <= agreed_ff;
      end
   end

   assign period_us   = rsp_period_ff;
   assign latest_code = rsp_latest_ff;
   assign agreed_code = rsp_agreed_ff;

endmodule

`default_nettype wire

// ----- design/bpc_controller.sv -----
// Controller: sequences capture, divide, ring write, agreement sweep and result handoff.
`default_nettype none

module bpc_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  bpc_pkg::ctrl_status_type  status,
   output bpc_pkg::ctrl_cmd_type     cmd
);
   import bpc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOAD  = 6'b000010,
      S_DIV   = 6'b000100,
      S_WRITE = 6'b001000,
      S_SWEEP = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.ring_write = 1'b1;
            state_in       = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/beacon_period_classifier_unit.sv -----
// Sequence per accepted req transaction: capture the edge, load the product, run M reciprocal
// multiply passes (3 at the default rate), write the ring, sweep N slots (N = effective sample
// count, 1..RING_DEPTH), then raise rsp_tvalid; a result held back by rsp_tready stalls the next.
// One transaction at a time: a new request is taken only once the result is loaded, the pace set
// by the chunked scaling and the one-slot-per-cycle agreement sweep through one classifier.
// Reset (synchronous): config to defaults, previous edge, ring and write index to zero.
`default_nettype none

module beacon_period_classifier_unit #(
   parameter int RING_DEPTH   = bpc_pkg::RING_DEPTH_DEFAULT,
   parameter int TICKS_PER_MS = bpc_pkg::TICKS_PER_MS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,   // [31:0] edge_time
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // [15:0] period_us, [18:16] latest_code,
                                                        // [21:19] agreed_code, [23:22] zero
   input  logic                            csr_we,
   input  bpc_pkg::csr_index_type          csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bpc_pkg::*;

   ctrl_cmd_type        cmd;
   ctrl_status_type     status;
   logic [PERIOD_W-1:0] rsp_period;
   code_type            rsp_latest;
   code_type            rsp_agreed;

   bpc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bpc_datapath #(
      .RING_DEPTH   (RING_DEPTH),
      .TICKS_PER_MS (TICKS_PER_MS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .edge_time   (req_tdata[EDGE_W-1:0]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .period_us   (rsp_period),
      .latest_code (rsp_latest),
      .agreed_code (rsp_agreed)
   );

   assign rsp_tdata = {2'b00, rsp_agreed, rsp_latest, rsp_period};

`ifndef NO_ASSERTIONS
   // one transaction at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted transaction");

   // a new result is only raised from a transaction in progress
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("rsp_tvalid rose while the block was idle");

   // the newest period sits in the checked slots, so agreement implies its class
   a_agree_matches_latest: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_agreed != CODE_INVALID)) |-> (rsp_agreed == rsp_latest))
      else $error("agreed code differs from latest code");

   a_codes_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_latest <= CODE_INVALID) && (rsp_agreed <= CODE_INVALID)))
      else $error("result code out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/beacon_period_classifier_unit_tb.sv -----
// Self-checking testbench for the beacon period classifier: directed and random edge streams.
module beacon_period_classifier_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam int RING_SLOTS   = RING_DEPTH_DEFAULT;
   localparam int TICKS_PER_US = TICKS_PER_MS_DEFAULT / US_PER_MS;
   localparam int RESET_CYCLES = 10;
   localparam int LATENCY_MAX  = 12 + RING_SLOTS;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;

   localparam csr_index_type REG_UNUSED = 3'd7;

   localparam nominal_array_type EXTREME_NOMINALS =
      {12'd0, 12'd300, 12'd1300, 12'd2600, 12'd4095};
   // sample_count sweep, entry 0 first; 0, 5 and 7 fall outside the ring
   localparam logic [6:0][COUNT_W-1:0] COUNT_SWEEP =
      {3'd4, 3'd7, 3'd0, 3'd2, 3'd5, 3'd1, 3'd3};

   typedef struct packed {
      logic [PERIOD_W-1:0] period_us;
      code_type            latest;
      code_type            agreed;
   } beacon_verdict_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;   // [31:0] edge_time
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;        // [15:0] period_us, [18:16] latest_code,
                                            // [21:19] agreed_code
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the block's configuration and measurement state
   logic [TOL_W-1:0]     cfg_tol;
   logic [COUNT_W-1:0]   cfg_count;
   logic [NOMINAL_W-1:0] cfg_nominal [BEACON_COUNT];
   logic [EDGE_W-1:0]    last_edge;
   logic [PERIOD_W-1:0]  period_ring [RING_SLOTS];
   int unsigned          ring_slot;

   beacon_verdict_type pending_verdicts [$];
   int unsigned     edges_accepted = 0;
   int unsigned     results_checked = 0;
   int unsigned     error_count = 0;
   logic [31:0]     stim_edge = '0;
   int unsigned     send_gap_pct = 0;
   int unsigned     recv_gap_pct = 0;
   bit              hold_request = 1'b0;

   beacon_period_classifier_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- shadow model

   function automatic void reset_shadow();
      int k;
      cfg_tol   = TOL_RESET;
      cfg_count = SAMPLE_RESET;
      for (k = 0; k < BEACON_COUNT; k++) cfg_nominal[k] = NOMINAL_RESET[k];
      last_edge = '0;
      for (k = 0; k < RING_SLOTS; k++) period_ring[k] = '0;
      ring_slot = 0;
   endfunction

   function automatic void apply_csr(input csr_index_type idx,
                                     input logic [CSR_DATA_W-1:0] wdata);
      case (idx)
         REG_TOLERANCE:    cfg_tol = wdata[TOL_W-1:0];
         REG_SAMPLE_COUNT: cfg_count = wdata[COUNT_W-1:0];
         default: begin
            if (idx >= REG_NOMINAL_0 && idx <= REG_NOMINAL_4)
               cfg_nominal[idx - REG_NOMINAL_0] = wdata[NOMINAL_W-1:0];
         end
      endcase
   endfunction

   function automatic int unsigned active_span();
      if (cfg_count == 0) return 1;
      if (cfg_count > RING_SLOTS) return RING_SLOTS;
      return cfg_count;
   endfunction

   // open windows, signed bounds; outer span first, then first matching beacon
   function automatic code_type window_class(input logic [PERIOD_W-1:0] period);
      int p, tol, center, k;
      p   = int'(period);
      tol = int'(cfg_tol);
      if (!(p < int'(cfg_nominal[0]) + tol && p > int'(cfg_nominal[BEACON_COUNT-1]) - tol))
         return CODE_INVALID;
      for (k = 0; k < BEACON_COUNT; k++) begin
         center = int'(cfg_nominal[k]);
         if (p > center - tol && p < center + tol) return code_type'(k);
      end
      return CODE_INVALID;
   endfunction

   function automatic beacon_verdict_type predict_verdict(input logic [EDGE_W-1:0] edge_time);
      logic [EDGE_W-1:0]   ticks;
      logic [63:0]         micros;
      logic [PERIOD_W-1:0] period;
      int unsigned         span, slot;
      beacon_verdict_type  v;
      ticks  = edge_time - last_edge;
      micros = {32'd0, ticks} * 64'(US_PER_MS) / 64'(TICKS_PER_MS_DEFAULT);
      period = (micros > 64'd65535) ? 16'hFFFF : micros[PERIOD_W-1:0];
      span   = active_span();
      if (ring_slot >= span) ring_slot = 0;
      period_ring[ring_slot] = period;
      ring_slot++;
      if (ring_slot >= span) ring_slot = 0;
      last_edge   = edge_time;
      v.period_us = period;
      v.latest    = window_class(period);
      v.agreed    = window_class(period_ring[0]);
      for (slot = 1; slot < span; slot++) begin
         if (window_class(period_ring[slot]) != v.agreed) begin
            v.agreed = CODE_INVALID;
            break;
         end
      end
      return v;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_verdict(input logic [23:0] data);
      beacon_verdict_type want;
      results_checked++;
      if (pending_verdicts.size() == 0) begin
         flag_error($sformatf("result %0d with nothing pending, data %h",
                              results_checked, data));
         return;
      end
      want = pending_verdicts.pop_front();
      if (data[15:0] !== want.period_us)
         flag_error($sformatf("result %0d period_us expected %0d got %0d",
                              results_checked, want.period_us, data[15:0]));
      if (data[18:16] !== want.latest)
         flag_error($sformatf("result %0d latest_code expected %0d got %0d",
                              results_checked, want.latest, data[18:16]));
      if (data[21:19] !== want.agreed)
         flag_error($sformatf("result %0d agreed_code expected %0d got %0d",
                              results_checked, want.agreed, data[21:19]));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_shadow();
      end else begin
         if (csr_we) apply_csr(csr_index, csr_wdata);
         if (req_tvalid && req_tready) pending_verdicts.push_back(predict_verdict(req_tdata));
         if (rsp_tvalid && rsp_tready) check_verdict(rsp_tdata);
      end
   end

   // result side ready, with an optional long hold-off
   initial begin : sink_ready
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_edge(input logic [31:0] edge_time);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= edge_time;
      stim_edge = edge_time;
      do @(posedge clock); while (!req_tready);
      edges_accepted++;
   endtask

   task automatic send_ticks(input logic [31:0] ticks);
      send_edge(stim_edge + ticks);
   endtask

   // jitter stays below one microsecond so the floor is unchanged
   task automatic send_period(input int us);
      send_ticks(32'(us * TICKS_PER_US) + $urandom_range(0, TICKS_PER_US - 1));
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] wdata);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // quiesce input and wait until every accepted edge has produced its result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_checked < edges_accepted) @(posedge clock);
      repeat (LATENCY_MAX) @(posedge clock);
   endtask

   // a period near beacon k: mostly inside its window, some on or past the edge
   function automatic int near_beacon(input int k);
      int center, tol, roll, offset;
      center = int'(cfg_nominal[k]);
      tol    = int'(cfg_tol);
      roll   = int'($urandom_range(0, 99));
      if (roll < 80 && tol > 0) begin
         offset = int'($urandom_range(0, 2 * tol - 2)) - (tol - 1);
      end else if (roll < 95) begin
         offset = tol + int'($urandom_range(0, 1));
         if ($urandom_range(0, 1) != 0) offset = -offset;
      end else begin
         return int'($urandom_range(0, 4200));
      end
      center += offset;
      return (center < 0) ? 0 : center;
   endfunction

   // runs of one beacon with some stray and garbage edges mixed in
   task automatic test_random_traffic(input int n);
      int sent, k, len, i, roll;
      sent = 0;
      while (sent < n) begin
         k   = $urandom_range(0, BEACON_COUNT - 1);
         len = $urandom_range(1, 8);
         for (i = 0; i < len && sent < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
               send_edge($urandom);
            else if (roll < 9)
               send_ticks($urandom_range(2621400, 2621480));
            else if (roll < 15)
               send_period(near_beacon($urandom_range(0, BEACON_COUNT - 1)));
            else
               send_period(near_beacon(k));
            sent++;
         end
      end
   endtask

   task automatic test_edge_extremes();
      send_edge(32'd32005);       // first edge counts from zero: 800 us
      send_edge(32'd0);           // backwards, wraps to a huge period
      send_edge(32'hFFFF_FFFF);
      send_edge(32'h0000_6BCF);   // across the wrap: 690 us
      send_ticks(32'd0);
      send_ticks(32'd2621439);    // largest unsaturated period
      send_ticks(32'd2621440);    // first saturated period
      send_ticks(32'hFFFF_FFFF);
   endtask

   task automatic test_window_bounds();
      send_period(790);   // on the lower bound of the 800 us window
      send_period(791);
      send_period(809);
      send_period(810);
      send_period(445);   // on the outer lower bound
      send_period(446);
      send_period(464);
      send_period(465);
      send_period(750);   // inside the span but in no window
   endtask

   task automatic test_agreement();
      repeat (RING_SLOTS) send_period(690);
      repeat (RING_SLOTS) send_period(513);
   endtask

   task automatic test_sample_counts();
      int i;
      for (i = 0; i < 7; i++) begin
         drain_results();
         write_csr(REG_SAMPLE_COUNT,
                   CSR_DATA_W'({9'($urandom_range(0, 511)), COUNT_SWEEP[i]}));
         test_random_traffic($urandom_range(13, 17));
      end
   endtask

   // sink holds off while edges keep coming, then the source waits for all results
   task automatic test_backpressure();
      int i;
      hold_request = 1'b1;
      for (i = 0; i < 12; i++) send_period(near_beacon($urandom_range(0, BEACON_COUNT - 1)));
      drain_results();
   endtask

   task automatic test_tolerance_and_nominals();
      int k;
      drain_results();
      write_csr(REG_TOLERANCE, 12'hF00);   // zero width: nothing classifies
      test_random_traffic(20);
      drain_results();
      write_csr(REG_TOLERANCE, 12'h0FF);   // overlapping windows, first wins
      test_random_traffic(30);
      drain_results();
      write_csr(REG_TOLERANCE, 12'd45);
      for (k = 0; k < BEACON_COUNT; k++)
         write_csr(csr_index_type'(REG_NOMINAL_0 + k), EXTREME_NOMINALS[k]);
      test_random_traffic(40);
      drain_results();
      write_csr(REG_TOLERANCE, CSR_DATA_W'($urandom));
      for (k = 0; k < BEACON_COUNT; k++)
         write_csr(csr_index_type'(REG_NOMINAL_0 + k), CSR_DATA_W'($urandom));
      write_csr(REG_UNUSED, CSR_DATA_W'($urandom));
      test_random_traffic(40);
   endtask

   task automatic test_full_rate();
      int k;
      drain_results();
      write_csr(REG_TOLERANCE, CSR_DATA_W'($urandom_range(3, 30)));
      write_csr(REG_SAMPLE_COUNT, CSR_DATA_W'(SAMPLE_RESET));
      for (k = 0; k < BEACON_COUNT; k++)
         write_csr(csr_index_type'(REG_NOMINAL_0 + k), NOMINAL_RESET[k]);
      test_random_traffic(150);
   endtask

   initial begin
      send_gap_pct = 14;
      recv_gap_pct = 88;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_extremes();
      test_window_bounds();
      test_agreement();
      test_random_traffic(120);
      test_sample_counts();

      send_gap_pct = 88;
      recv_gap_pct = 14;
      test_backpressure();
      test_tolerance_and_nominals();

      send_gap_pct = 0;
      recv_gap_pct = 0;
      test_full_rate();

      drain_results();
      if (pending_verdicts.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_verdicts.size()));
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/bpc_pkg.sv
design/bpc_classifier.sv
design/bpc_datapath.sv
design/bpc_controller.sv
design/beacon_period_classifier_unit.sv
tb/sv/beacon_period_classifier_unit_tb.sv
